// ===== hw/rtl/sera_pkg.sv =====
package sera_pkg;

    localparam int AVG_DEPTH  = 4;
    localparam int TICKS_W    = 16;
    localparam int CM_W       = 10;
    localparam int ANGLE_W    = 9;
    localparam int RETRY_W    = 8;
    localparam int RING_AW    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W      = CM_W + $clog2(AVG_DEPTH);
    localparam int DIV_CNT_W  = $clog2(TICKS_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE_CM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_MODE  = 3'd4;

    localparam logic [CM_W-1:0]    RST_TICKS_PER_CM = 10'd87;
    localparam logic [CM_W-1:0]    RST_MAX_RANGE_CM = 10'd400;
    localparam logic [RETRY_W-1:0] RST_MAX_RETRIES  = 8'd3;
    localparam logic [RETRY_W-1:0] RETRY_SAT        = 8'd255;

    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
        logic [CM_W-1:0]    data;
    } t_ring_wr;

endpackage

// ===== hw/rtl/sonar_echo_range_averager_top.sv =====
// Channel     Dir  Fields (low bit up)
// s_axis      in   echo_ticks[15:0], timer_overflowed[16], servo_angle[25:17], zero[31:26]
// m_axis      out  report_valid[0], avg_range_cm[10:1], report_angle[19:11],
//                  advance_sweep[20], finish_single[21], rearm_trigger[22], zero[23]
// cfg         in   write enable, register index, data; no read-back
//
// An echo whose timer overflowed skips the divider and goes straight to the update step.
// A normal echo goes through the serial divider first. Every echo then passes the update
// and decision steps, a summing pass over the ring memory's read port when the report
// carries the ring average, then output load and back to idle.
// Reset is synchronous and clears the ring valid bits, position and retry count.
// One echo is in flight at a time; a new one is taken while a result waits in
// the output register, and the next result holds until that register drains.
module sonar_echo_range_averager_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // echo_ticks, timer_overflowed, servo_angle, zero pad
    input  logic [sera_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // report_valid, avg_range_cm, report_angle, advance_sweep,
    // finish_single, rearm_trigger, zero pad
    output logic [sera_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [sera_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sera_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import sera_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_UPD    = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_SUM    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [CM_W-1:0]    r_ticks_per_cm;
    logic [CM_W-1:0]    r_max_range;
    logic [RETRY_W-1:0] r_max_retries;
    logic               r_sweep;
    logic               r_single;

    logic [2:0]         r_state;
    logic [RETRY_W-1:0] r_retry;
    logic [RING_AW-1:0] r_pos;

    logic               r_ovf;
    logic [ANGLE_W-1:0] r_angle;

    logic               r_valid;
    logic               r_adv;
    logic               r_fin;
    logic               r_rearm;
    logic [CM_W-1:0]    r_dist;

    logic               r_out_vld;
    logic [M_TDATA_W-1:0] r_out_data;

    logic               accept;
    logic               div_start;
    logic               div_done;
    logic [TICKS_W-1:0] quotient;
    logic [CM_W-1:0]    divisor;
    logic               in_range;
    logic [RETRY_W-1:0] retry_inc;
    t_ring_wr           ring_wr;
    logic               sum_start;
    logic               sum_done;
    logic [SUM_W-1:0]   sum;
    logic               out_load;

    logic               d_valid;
    logic               d_avg;
    logic               d_adv;
    logic               d_fin;
    logic               d_rearm;
    logic               d_clr;
    logic               rz;
    logic               pz;

    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign div_start = accept && !i_s_axis_tdata[TICKS_W];
    assign divisor   = (r_ticks_per_cm == '0) ? CM_W'(1) : r_ticks_per_cm;
    assign in_range  = !r_ovf && (quotient < TICKS_W'(r_max_range));
    assign retry_inc = (r_retry == RETRY_SAT) ? r_retry : r_retry + 1'b1;

    assign ring_wr.en   = (r_state == ST_UPD) && in_range;
    assign ring_wr.addr = r_pos;
    assign ring_wr.data = quotient[CM_W-1:0];

    sera_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_s_axis_tdata[TICKS_W-1:0]),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    sera_ring u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (ring_wr),
        .i_sum_start (sum_start),
        .o_sum_done  (sum_done),
        .o_sum       (sum)
    );

    always_comb begin
        rz      = (r_retry == '0);
        pz      = (r_pos == '0);
        d_valid = 1'b0;
        d_avg   = 1'b0;
        d_adv   = 1'b0;
        d_fin   = 1'b0;
        d_clr   = 1'b0;
        d_rearm = r_rearm;
        if (r_ovf) begin
            d_rearm = 1'b1;
            if (r_sweep && (r_retry > r_max_retries)) begin
                d_clr = 1'b1;
                d_adv = 1'b1;
            end
        end else if (r_sweep && pz && rz) begin
            d_valid = 1'b1;
            d_avg   = 1'b1;
            d_adv   = 1'b1;
        end else if (r_sweep && (r_retry > r_max_retries)) begin
            d_clr = 1'b1;
            d_adv = 1'b1;
        end else if (!r_sweep && !r_single) begin
            if (rz) begin
                d_valid = 1'b1;
                d_avg   = 1'b1;
            end else if (r_retry >= r_max_retries) begin
                d_clr   = 1'b1;
                d_valid = 1'b1;
            end
            d_rearm = 1'b1;
        end else if (r_single && pz) begin
            if (rz) begin
                d_valid = 1'b1;
                d_avg   = 1'b1;
                d_fin   = 1'b1;
                d_rearm = 1'b0;
            end else if (r_retry >= r_max_retries) begin
                d_clr   = 1'b1;
                d_valid = 1'b1;
                d_fin   = 1'b1;
                d_rearm = 1'b0;
            end
        end else begin
            d_rearm = 1'b1;
        end
    end

    assign sum_start = (r_state == ST_DECIDE) && d_avg;
    assign out_load  = (r_state == ST_OUT) && (!r_out_vld || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_cm <= RST_TICKS_PER_CM;
            r_max_range    <= RST_MAX_RANGE_CM;
            r_max_retries  <= RST_MAX_RETRIES;
            r_sweep        <= 1'b0;
            r_single       <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_TICKS_PER_CM: r_ticks_per_cm <= i_cfg_wdata[CM_W-1:0];
                REG_MAX_RANGE_CM: r_max_range    <= i_cfg_wdata[CM_W-1:0];
                REG_MAX_RETRIES:  r_max_retries  <= i_cfg_wdata[RETRY_W-1:0];
                REG_SWEEP_MODE:   r_sweep        <= i_cfg_wdata[0];
                REG_SINGLE_MODE:  r_single       <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ovf   <= i_s_axis_tdata[TICKS_W];
            r_angle <= i_s_axis_tdata[TICKS_W+ANGLE_W:TICKS_W+1];
        end
        if (r_state == ST_UPD) begin
            r_rearm <= !in_range;
        end
        if (r_state == ST_DECIDE) begin
            r_valid <= d_valid;
            r_adv   <= d_adv;
            r_fin   <= d_fin;
            r_rearm <= d_rearm;
            r_dist  <= '0;
        end
        if (sum_done) begin
            r_dist <= CM_W'(sum / AVG_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_retry   <= '0;
            r_pos     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= i_s_axis_tdata[TICKS_W] ? ST_UPD : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (in_range) begin
                        r_retry <= '0;
                        if (r_pos == RING_AW'(AVG_DEPTH - 1)) begin
                            r_pos <= '0;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end else begin
                        r_retry <= retry_inc;
                    end
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (d_clr) begin
                        r_retry <= '0;
                    end
                    r_state <= d_avg ? ST_SUM : ST_OUT;
                end
                ST_SUM: begin
                    if (sum_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {1'b0, r_rearm, r_fin, r_adv,
                           r_valid ? r_angle : '0,
                           r_valid ? r_dist : '0,
                           r_valid};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sum_done |-> (r_state == ST_SUM))
        else $error("ring sum finished outside the summing step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_wr.en |=> (r_state == ST_DECIDE) && !sum_done)
        else $error("ring write overlaps a summing pass");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[21]) |-> !o_m_axis_tdata[22])
        else $error("finish_single with rearm_trigger set");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("output register overwritten while full");

endmodule

// ===== hw/rtl/sera_divider.sv =====
module sera_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sera_pkg::TICKS_W-1:0] i_dividend,
    input  logic [sera_pkg::CM_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [sera_pkg::TICKS_W-1:0] o_quotient
);
    import sera_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CM_W-1:0]      r_rem;
    logic [TICKS_W-1:0]   r_quo;
    logic [CM_W-1:0]      r_div;

    logic [CM_W:0]        trial;
    logic                 q_bit;
    logic [CM_W-1:0]      n_rem;

    always_comb begin
        trial = {r_rem, r_quo[TICKS_W-1]};
        q_bit = (trial >= {1'b0, r_div});
        n_rem = q_bit ? CM_W'(trial - {1'b0, r_div}) : CM_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[TICKS_W-2:0], q_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(TICKS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/sera_ring.sv =====
module sera_ring (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sera_pkg::t_ring_wr         i_wr,
    input  logic                       i_sum_start,
    output logic                       o_sum_done,
    output logic [sera_pkg::SUM_W-1:0] o_sum
);
    import sera_pkg::*;

    logic [CM_W-1:0]      mem [AVG_DEPTH];
    logic [AVG_DEPTH-1:0] r_valid;
    logic [CM_W-1:0]      r_rd_word;
    logic                 r_rd_ok;
    logic [RING_AW-1:0]   r_idx;
    logic                 r_busy;
    logic                 r_pend;
    logic                 r_last;
    logic                 r_done;
    logic [SUM_W-1:0]     r_acc;
    logic [CM_W-1:0]      rd_word;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_word <= mem[r_idx];
    end

    assign rd_word = r_rd_ok ? r_rd_word : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
            r_busy  <= 1'b0;
            r_pend  <= 1'b0;
            r_last  <= 1'b0;
            r_done  <= 1'b0;
            r_idx   <= '0;
            r_acc   <= '0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_ok <= r_valid[r_idx];
            r_pend  <= r_busy;
            r_last  <= r_busy && (r_idx == RING_AW'(AVG_DEPTH - 1));
            r_done  <= r_last;
            if (i_sum_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_acc  <= '0;
            end else begin
                if (r_busy) begin
                    if (r_idx == RING_AW'(AVG_DEPTH - 1)) begin
                        r_busy <= 1'b0;
                        r_idx  <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                if (r_pend) begin
                    r_acc <= r_acc + SUM_W'(rd_word);
                end
            end
        end
    end

    assign o_sum_done = r_done;
    assign o_sum      = r_acc;

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import sera_pkg::*;

    localparam int STUCK_LIMIT = 4000;

    typedef struct packed {
        logic               rep_valid;
        logic [CM_W-1:0]    dist_cm;
        logic [ANGLE_W-1:0] angle;
        logic               adv;
        logic               fin;
        logic               rearm;
    } t_report;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wval;
        logic [TICKS_W-1:0]    ticks;
        logic                  ovf;
        logic [ANGLE_W-1:0]    angle;
        logic                  typed;
        t_report               res;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // echo_ticks, timer_overflowed, servo_angle, zero pad
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // report_valid, avg_range_cm, report_angle, advance_sweep,
    // finish_single, rearm_trigger, zero pad
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    sonar_echo_range_averager_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor copy of the block's registers and state
    logic [CM_W-1:0]    tpc_r;
    logic [CM_W-1:0]    range_r;
    logic [RETRY_W-1:0] maxret_r;
    logic               sweep_r;
    logic               single_r;
    logic [CM_W-1:0]    ring_m [AVG_DEPTH];
    int unsigned        pos_m;
    logic [RETRY_W-1:0] retries_m;

    t_report  pending_reports[$];
    t_dir_row dir_tab[$];
    int       mismatches = 0;
    int       stuck_cycles = 0;
    int       idle_mode = 0;
    int       sent_count = 0;

    function automatic t_report rpt(bit v, int d, int a, bit adv, bit fin, bit rearm);
        t_report r;
        r.rep_valid = v;
        r.dist_cm   = CM_W'(d);
        r.angle     = ANGLE_W'(a);
        r.adv       = adv;
        r.fin       = fin;
        r.rearm     = rearm;
        return r;
    endfunction

    function automatic logic [CM_W-1:0] ring_mean();
        int unsigned sum;
        sum = 0;
        for (int k = 0; k < AVG_DEPTH; k++) sum += ring_m[k];
        return CM_W'(sum / AVG_DEPTH);
    endfunction

    function automatic t_report echo_outcome(logic [TICKS_W-1:0] ticks, logic ovf,
                                             logic [ANGLE_W-1:0] angle);
        t_report     r;
        int unsigned div;
        int unsigned cm;
        r = '0;
        if (ovf) begin
            if (retries_m != RETRY_SAT) retries_m++;
            r.rearm = 1'b1;
            if (sweep_r && retries_m > maxret_r) begin
                retries_m = '0;
                r.adv = 1'b1;
            end
        end else begin
            div = (tpc_r == 0) ? 1 : tpc_r;
            cm  = ticks / div;
            if (cm < range_r) begin
                retries_m = '0;
                ring_m[pos_m] = CM_W'(cm);
                pos_m = (pos_m + 1) % AVG_DEPTH;
            end else begin
                if (retries_m != RETRY_SAT) retries_m++;
                r.rearm = 1'b1;
            end
            if (sweep_r && pos_m == 0 && retries_m == 0) begin
                r.rep_valid = 1'b1;
                r.dist_cm   = ring_mean();
                r.adv       = 1'b1;
            end else if (sweep_r && retries_m > maxret_r) begin
                retries_m = '0;
                r.adv = 1'b1;
            end else if (!sweep_r && !single_r) begin
                if (retries_m == 0) begin
                    r.rep_valid = 1'b1;
                    r.dist_cm   = ring_mean();
                end else if (retries_m >= maxret_r) begin
                    retries_m   = '0;
                    r.rep_valid = 1'b1;
                    r.dist_cm   = '0;
                end
                r.rearm = 1'b1;
            end else if (single_r && pos_m == 0) begin
                if (retries_m == 0) begin
                    r.rep_valid = 1'b1;
                    r.dist_cm   = ring_mean();
                    r.fin       = 1'b1;
                end else if (retries_m >= maxret_r) begin
                    retries_m   = '0;
                    r.rep_valid = 1'b1;
                    r.dist_cm   = '0;
                    r.fin       = 1'b1;
                end
                if (r.fin) r.rearm = 1'b0;
            end else begin
                r.rearm = 1'b1;
            end
        end
        if (r.rep_valid) r.angle = angle;
        return r;
    endfunction

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int val);
        t_dir_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.wval   = CFG_DATA_W'(val);
        dir_tab.push_back(row);
    endtask

    task automatic add_echo(int ticks, bit ovf, int angle, bit typed, t_report res);
        t_dir_row row;
        row = '0;
        row.ticks = TICKS_W'(ticks);
        row.ovf   = ovf;
        row.angle = ANGLE_W'(angle);
        row.typed = typed;
        row.res   = res;
        dir_tab.push_back(row);
    endtask

    // drain the block, then write one register
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_TICKS_PER_CM: tpc_r    = val[CM_W-1:0];
            REG_MAX_RANGE_CM: range_r  = val[CM_W-1:0];
            REG_MAX_RETRIES:  maxret_r = val[RETRY_W-1:0];
            REG_SWEEP_MODE:   sweep_r  = val[0];
            REG_SINGLE_MODE:  single_r = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_cfg(int tpc, int range, int maxret, int sweep, int single);
        cfg_write(REG_TICKS_PER_CM, CFG_DATA_W'(tpc));
        cfg_write(REG_MAX_RANGE_CM, CFG_DATA_W'(range));
        cfg_write(REG_MAX_RETRIES,  CFG_DATA_W'(maxret));
        cfg_write(REG_SWEEP_MODE,   CFG_DATA_W'(sweep));
        cfg_write(REG_SINGLE_MODE,  CFG_DATA_W'(single));
    endtask

    task automatic send_echo(logic [TICKS_W-1:0] ticks, logic ovf, logic [ANGLE_W-1:0] angle,
                             bit typed, t_report typed_res);
        int unsigned gap_pct;
        t_report     r;
        idle_mode = (sent_count / 25) % 4;
        gap_pct = (idle_mode == 1) ? 54 : (idle_mode == 3) ? 23 : 0;
        if ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(S_TDATA_W-TICKS_W-1-ANGLE_W){1'b0}}, angle, ovf, ticks};
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = echo_outcome(ticks, ovf, angle);
        pending_reports.push_back(typed ? typed_res : r);
        sent_count++;
    endtask

    // mostly in-range echoes, plus range edges, extremes and noise
    task automatic pick_echo(output logic [TICKS_W-1:0] ticks, output logic ovf,
                             output logic [ANGLE_W-1:0] angle);
        int unsigned div;
        int unsigned top;
        int unsigned cm;
        int unsigned lim;
        int unsigned kind;
        int          a;
        div  = (tpc_r == 0) ? 1 : tpc_r;
        top  = 65535 / div;
        kind = $urandom_range(99);
        ovf  = ($urandom_range(99) < 15);
        if (kind < 55 && range_r != 0) begin
            cm  = $urandom_range((range_r - 1 < top) ? range_r - 1 : top);
            lim = cm * div + $urandom_range(div - 1);
            ticks = (lim > 65535) ? 16'hFFFF : TICKS_W'(lim);
        end else if (kind < 75) begin
            lim = range_r * div;
            if (lim > 65535) lim = 65535;
            if (lim > 0) lim = lim - $urandom_range(1);
            ticks = TICKS_W'(lim);
        end else if (kind < 85) begin
            ticks = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end else begin
            ticks = TICKS_W'($urandom_range(65535));
        end
        a = int'($urandom_range(360)) - 180;
        angle = ANGLE_W'(a);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report     got;
        t_report     want;
        int unsigned stall_pct;
        stall_pct = (idle_mode == 2) ? 54 : (idle_mode == 3) ? 23 : 0;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.rep_valid = o_m_axis_tdata[0];
            got.dist_cm   = o_m_axis_tdata[10:1];
            got.angle     = o_m_axis_tdata[19:11];
            got.adv       = o_m_axis_tdata[20];
            got.fin       = o_m_axis_tdata[21];
            got.rearm     = o_m_axis_tdata[22];
            if (pending_reports.size() == 0) begin
                $error("report transfer with no echo pending");
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("report_valid", want.rep_valid, got.rep_valid);
                check_field("avg_range_cm", want.dist_cm, got.dist_cm);
                check_field("report_angle", int'($signed(want.angle)),
                            int'($signed(got.angle)));
                check_field("advance_sweep", want.adv, got.adv);
                check_field("finish_single", want.fin, got.fin);
                check_field("rearm_trigger", want.rearm, got.rearm);
            end
        end
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || i_cfg_wr_en) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin : watchdog
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("[sonar_echo_range_averager_top] ERROR");
        $finish;
    end

    initial begin
        logic [TICKS_W-1:0] t;
        logic               o;
        logic [ANGLE_W-1:0] a;
        int                 n;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_wdata     <= '0;
        tpc_r     = RST_TICKS_PER_CM;
        range_r   = RST_MAX_RANGE_CM;
        maxret_r  = RST_MAX_RETRIES;
        sweep_r   = 1'b0;
        single_r  = 1'b1;
        pos_m     = 0;
        retries_m = '0;
        for (int k = 0; k < AVG_DEPTH; k++) ring_m[k] = '0;

        // single mode after reset, ring partly filled, range edges
        add_echo(870,   0,    0, 1, rpt(0, 0, 0, 0, 0, 1));
        add_echo(65535, 1, -180, 1, rpt(0, 0, 0, 0, 0, 1));
        add_echo(0,     0,  180, 1, rpt(0, 0, 0, 0, 0, 1));
        add_echo(65535, 0,   -1, 1, rpt(0, 0, 0, 0, 0, 1));
        add_echo(34713, 0,  100, 1, rpt(0, 0, 0, 0, 0, 1));
        add_echo(34800, 0, -100, 1, rpt(0, 0, 0, 0, 0, 1));
        add_echo(86,    0,   45, 1, rpt(1, 102, 45, 0, 1, 0));
        add_echo(0,     1,    1, 1, rpt(0, 0, 0, 0, 0, 1));
        add_echo(65535, 0,    2, 1, rpt(0, 0, 0, 0, 0, 1));
        add_echo(65535, 0,   -1, 1, rpt(1, 0, -1, 0, 1, 0));
        // continuous mode
        add_cfg(REG_SINGLE_MODE, 0);
        add_echo(8700,  0,  -45, 0, '0);
        add_echo(0,     1,   -2, 0, '0);
        add_echo(65535, 0,   90, 0, '0);
        add_echo(65535, 0,   91, 0, '0);
        // zero divisor, widest range
        add_cfg(REG_TICKS_PER_CM, 0);
        add_cfg(REG_MAX_RANGE_CM, 1023);
        add_echo(1022,  0,   10, 0, '0);
        add_echo(1023,  0,   11, 0, '0);
        add_echo(65535, 0,   12, 0, '0);
        // sweep with no retries
        add_cfg(REG_SWEEP_MODE, 1);
        add_cfg(REG_MAX_RETRIES, 0);
        add_cfg(REG_TICKS_PER_CM, 1023);
        add_echo(65535, 1, -180, 1, rpt(0, 0, 0, 1, 0, 1));
        add_echo(65535, 0,    0, 0, '0);
        add_echo(2046,  0,    1, 0, '0);
        add_echo(3069,  0,    2, 0, '0);
        add_echo(0,     0,    3, 0, '0);
        // sweep and single together
        add_cfg(REG_SINGLE_MODE, 1);
        add_echo(0,     0,    4, 0, '0);
        add_echo(1023,  1,    5, 0, '0);
        add_echo(65535, 0,    6, 0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                cfg_write(dir_tab[k].idx, dir_tab[k].wval);
            end else begin
                send_echo(dir_tab[k].ticks, dir_tab[k].ovf, dir_tab[k].angle,
                          dir_tab[k].typed, dir_tab[k].res);
            end
        end

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_cfg(87, 400, 3, 0, 0);
                1: set_cfg(1, 1023, 0, 1, 0);
                2: set_cfg(1023, 1, 1, 0, 1);
                3: set_cfg(0, 1023, 2, 1, 1);
                4: set_cfg(300, 0, 255, 1, 0);
                5: set_cfg(64, 200, 255, 0, 0);
                default: begin
                    set_cfg($urandom_range(1023), $urandom_range(1023), $urandom_range(255),
                            $urandom_range(1), $urandom_range(1));
                end
            endcase
            // saturate the retry count: every echo fails at zero range
            n = (ph == 4) ? 270 : 60;
            for (int k = 0; k < n; k++) begin
                pick_echo(t, o, a);
                send_echo(t, o, a, 0, '0);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("[sonar_echo_range_averager_top] OK");
        end else begin
            $display("[sonar_echo_range_averager_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sera_pkg.sv
hw/rtl/sera_divider.sv
hw/rtl/sera_ring.sv
hw/rtl/sonar_echo_range_averager_top.sv
tb/testbench.sv
